FILE: sv/polylen_pkg.sv
// Shared constants for the polyline length accumulator.
// Widths of the stream fields, store depth, request kinds and sequencer states.
// No dependencies.
package polylen_pkg;

    localparam int MAX_POINTS   = 256;
    localparam int ADDR_WIDTH   = $clog2(MAX_POINTS);
    localparam int COUNT_WIDTH  = $clog2(MAX_POINTS + 1);
    localparam int COORD_WIDTH  = 16;
    localparam int LENGTH_WIDTH = 32;

    // |dx|, |dy| fit COORD_WIDTH bits; their squared sum needs one more bit than a square
    localparam int SQ_WIDTH     = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH    = SQ_WIDTH + 1;
    localparam int ROOT_WIDTH   = (SUM_WIDTH + 1) / 2;
    localparam int RAD_WIDTH    = 2 * ROOT_WIDTH;
    localparam int REM_WIDTH    = ROOT_WIDTH + 2;
    localparam int STEP_WIDTH   = $clog2(ROOT_WIDTH);

    localparam int S_TDATA_WIDTH = 40;
    localparam int M_TDATA_WIDTH = 80;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQX  = 3'd1;
    localparam logic [2:0] ST_SQY  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_RD   = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

endpackage

FILE: sv/polyline_length_accumulator.sv
// Polyline length accumulator: point store, shared multiplier and a
// digit-by-digit square root under one small sequencer.
// Depends on polylen_pkg.
//
// Usage:
//   Input stream s_*: s_tuser is the kind (0 append, 1 read). An append stores
//   (x_in, y_in) and adds the floor distance from the previous point to the
//   running length, which saturates at all ones. A read returns the point at
//   point_index. Each transfer in yields exactly one transfer on m_*, carrying
//   the point read (zero for appends and failed reads), the point count, the length and an
//   error flag (append to a full store, or read at or beyond the count).
//   Steps: an append runs two multiplier passes, 17 root steps, one accumulate
//   and one output load; the first point and a dropped append go straight to
//   the output load, a read through a store read first. s_tready is high only
//   while the sequencer idles, so no item is taken until the last has reached
//   the output register; the root loop sets the append rate.
//   A result waits in the output register while m_tready is low; the next
//   input is still taken and held back at its end until the register frees.
//   Reset (aresetn low at a clock edge) empties the store, clears the length
//   and previous point and drops any pending result.
module polyline_length_accumulator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [15:0] x_in, [31:16] y_in, [39:32] point_index
    input  logic [polylen_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // [0] kind
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [15:0] x_out, [31:16] y_out, [40:32] point_count, [72:41] total_length,
    // [73] error_flag, [79:74] zero
    output logic [polylen_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    localparam int CW = polylen_pkg::COORD_WIDTH;
    localparam int NW = polylen_pkg::COUNT_WIDTH;
    localparam int AW = polylen_pkg::ADDR_WIDTH;
    localparam int LW = polylen_pkg::LENGTH_WIDTH;
    localparam int RW = polylen_pkg::ROOT_WIDTH;
    localparam int QW = polylen_pkg::SUM_WIDTH;
    localparam int DW = polylen_pkg::RAD_WIDTH;
    localparam int EW = polylen_pkg::REM_WIDTH;
    localparam int TW = polylen_pkg::STEP_WIDTH;

    logic [2:0]      state_reg, state_next;
    logic [NW-1:0]   count_reg, count_next;
    logic [LW-1:0]   length_reg, length_next;
    logic [CW-1:0]   prev_x_reg, prev_x_next;
    logic [CW-1:0]   prev_y_reg, prev_y_next;
    logic [CW-1:0]   ax_reg, ax_next;
    logic [CW-1:0]   ay_reg, ay_next;
    logic [QW-1:0]   sum_reg, sum_next;
    logic [DW-1:0]   rad_reg, rad_next;
    logic [EW-1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [TW-1:0]   step_reg, step_next;
    logic            is_read_reg, is_read_next;
    logic            err_reg, err_next;
    logic [AW-1:0]   idx_reg, idx_next;

    logic            m_valid_reg, m_valid_next;
    logic [CW-1:0]   m_x_reg, m_x_next;
    logic [CW-1:0]   m_y_reg, m_y_next;
    logic [NW-1:0]   m_count_reg, m_count_next;
    logic [LW-1:0]   m_length_reg, m_length_next;
    logic            m_err_reg, m_err_next;

    logic [2*CW-1:0] store_mem [polylen_pkg::MAX_POINTS];
    logic [2*CW-1:0] rd_data_reg;
    logic            wr_en;

    logic [CW-1:0]   x_in, y_in;
    logic [AW-1:0]   point_index;
    logic            s_fire;
    logic            full;
    logic [CW:0]     dx, dy;
    logic [CW:0]     dx_abs, dy_abs;
    logic [CW-1:0]   mul_a;
    logic [2*CW-1:0] product;
    logic [EW+1:0]   rem_shift, trial, rem_diff;
    logic [LW:0]     length_sum;

    assign x_in        = s_tdata[CW-1:0];
    assign y_in        = s_tdata[2*CW-1:CW];
    assign point_index = s_tdata[2*CW+AW-1:2*CW];

    assign s_tready = (state_reg == polylen_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign full     = (count_reg == NW'(polylen_pkg::MAX_POINTS));
    assign wr_en    = s_fire && (s_tuser == polylen_pkg::KIND_APPEND) && !full;

    // sign-extended differences; the magnitude always fits CW bits
    assign dx     = {x_in[CW-1], x_in} - {prev_x_reg[CW-1], prev_x_reg};
    assign dy     = {y_in[CW-1], y_in} - {prev_y_reg[CW-1], prev_y_reg};
    assign dx_abs = dx[CW] ? -dx : dx;
    assign dy_abs = dy[CW] ? -dy : dy;

    // shared multiplier: squares |dx| then |dy|
    assign mul_a   = (state_reg == polylen_pkg::ST_SQX) ? ax_reg : ay_reg;
    assign product = mul_a * mul_a;

    // one restoring root step: bring down two radicand bits, try root*4+1
    assign rem_shift  = {rem_reg, rad_reg[DW-1:DW-2]};
    assign trial      = {1'b0, root_reg, 2'b01};
    assign rem_diff   = rem_shift - trial;
    assign length_sum = {1'b0, length_reg} + (LW + 1)'(root_reg);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        sum_next      = sum_reg;
        rad_next      = rad_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        step_next     = step_reg;
        is_read_next  = is_read_reg;
        err_next      = err_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_x_next      = m_x_reg;
        m_y_next      = m_y_reg;
        m_count_next  = m_count_reg;
        m_length_next = m_length_reg;
        m_err_next    = m_err_reg;

        case (state_reg)
            polylen_pkg::ST_IDLE: begin
                if (s_fire) begin
                    is_read_next = (s_tuser == polylen_pkg::KIND_READ);
                    idx_next     = point_index;
                    if (s_tuser == polylen_pkg::KIND_READ) begin
                        err_next   = ({1'b0, point_index} >= count_reg);
                        state_next = polylen_pkg::ST_RD;
                    end else if (full) begin
                        err_next   = 1'b1;
                        state_next = polylen_pkg::ST_FIN;
                    end else begin
                        err_next    = 1'b0;
                        ax_next     = dx_abs[CW-1:0];
                        ay_next     = dy_abs[CW-1:0];
                        prev_x_next = x_in;
                        prev_y_next = y_in;
                        count_next  = count_reg + NW'(1);
                        // first point adds no distance
                        state_next  = (count_reg == '0) ? polylen_pkg::ST_FIN
                                                        : polylen_pkg::ST_SQX;
                    end
                end
            end
            polylen_pkg::ST_SQX: begin
                sum_next   = QW'(product);
                state_next = polylen_pkg::ST_SQY;
            end
            polylen_pkg::ST_SQY: begin
                rad_next   = DW'(sum_reg + QW'(product));
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = polylen_pkg::ST_ROOT;
            end
            polylen_pkg::ST_ROOT: begin
                rad_next = {rad_reg[DW-3:0], 2'b00};
                if (rem_shift >= trial) begin
                    rem_next  = rem_diff[EW-1:0];
                    root_next = {root_reg[RW-2:0], 1'b1};
                end else begin
                    rem_next  = rem_shift[EW-1:0];
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                step_next = step_reg + TW'(1);
                if (step_reg == TW'(RW - 1)) begin
                    state_next = polylen_pkg::ST_ACC;
                end
            end
            polylen_pkg::ST_ACC: begin
                length_next = length_sum[LW] ? '1 : length_sum[LW-1:0];
                state_next  = polylen_pkg::ST_FIN;
            end
            polylen_pkg::ST_RD: begin
                // store read lands in rd_data_reg at this edge
                state_next = polylen_pkg::ST_FIN;
            end
            polylen_pkg::ST_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_count_next  = count_reg;
                    m_length_next = length_reg;
                    m_err_next    = err_reg;
                    if (is_read_reg && !err_reg) begin
                        m_x_next = rd_data_reg[CW-1:0];
                        m_y_next = rd_data_reg[2*CW-1:CW];
                    end else begin
                        m_x_next = '0;
                        m_y_next = '0;
                    end
                    state_next = polylen_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = polylen_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= polylen_pkg::ST_IDLE;
            count_reg   <= '0;
            length_reg  <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        sum_reg      <= sum_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        step_reg     <= step_next;
        is_read_reg  <= is_read_next;
        err_reg      <= err_next;
        idx_reg      <= idx_next;
        m_x_reg      <= m_x_next;
        m_y_reg      <= m_y_next;
        m_count_reg  <= m_count_next;
        m_length_reg <= m_length_next;
        m_err_reg    <= m_err_next;
    end

    // point store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[count_reg[AW-1:0]] <= {y_in, x_in};
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(polylen_pkg::M_TDATA_WIDTH - 2*CW - NW - LW - 1){1'b0}},
                       m_err_reg, m_length_reg, m_count_reg, m_y_reg, m_x_reg};

endmodule

FILE: dv/polyline_length_accumulator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for polyline_length_accumulator: appends and reads
// against a behavioural model of the point store and running length.
// Depends on polylen_pkg and the polyline_length_accumulator RTL.
module polyline_length_accumulator_tb;

    localparam int RANDOM_ITEMS = 1080;
    localparam int CALM_TAIL    = 100;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic               kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         idx;
        bit                 drain;
    } path_item_t;

    // laid out as m_tdata[73:0]
    typedef struct packed {
        logic        err;
        logic [31:0] length;
        logic [8:0]  count;
        logic [15:0] y;
        logic [15:0] x;
    } path_result_t;

    logic                                  aclk = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [polylen_pkg::S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic                                  s_tuser = 1'b0;
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic [polylen_pkg::M_TDATA_WIDTH-1:0] m_tdata;

    // model state of the polyline
    logic signed [15:0] pt_x [polylen_pkg::MAX_POINTS];
    logic signed [15:0] pt_y [polylen_pkg::MAX_POINTS];
    int                 pt_count = 0;
    logic [31:0]        path_length = '0;
    logic signed [15:0] last_x = '0;
    logic signed [15:0] last_y = '0;

    path_item_t   pending_q [$];
    path_result_t result_due_q [$];
    path_item_t   on_bus;
    int           sent_count = 0;
    int           total_items = 0;
    int           fail_count = 0;
    int           send_gap = 0;
    int           recv_stall = 0;
    bit           hold_done = 1'b0;

    polyline_length_accumulator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Apply one item to the model polyline and return the result it yields.
    function automatic path_result_t advance_polyline(path_item_t it);
        path_result_t      r;
        longint            dx, dy;
        longint unsigned   ax, ay, sq, root, trial, sum;
        int                b;
        r = '0;
        if (it.kind == polylen_pkg::KIND_APPEND) begin
            if (pt_count >= polylen_pkg::MAX_POINTS) begin
                r.err = 1'b1;
            end else begin
                if (pt_count != 0) begin
                    dx = longint'(it.x) - longint'(last_x);
                    dy = longint'(it.y) - longint'(last_y);
                    ax = (dx < 0) ? -dx : dx;
                    ay = (dy < 0) ? -dy : dy;
                    sq = ax * ax + ay * ay;
                    // build the floor root a bit at a time from the top
                    root = 0;
                    for (b = 17; b >= 0; b--) begin
                        trial = root | (64'd1 << b);
                        if (trial * trial <= sq)
                            root = trial;
                    end
                    sum = longint'(path_length) + root;
                    path_length = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                end
                pt_x[pt_count] = it.x;
                pt_y[pt_count] = it.y;
                pt_count++;
                last_x = it.x;
                last_y = it.y;
            end
        end else begin
            if (int'(it.idx) >= pt_count) begin
                r.err = 1'b1;
            end else begin
                r.x = pt_x[it.idx];
                r.y = pt_y[it.idx];
            end
        end
        r.count  = pt_count[8:0];
        r.length = path_length;
        return r;
    endfunction

    function automatic bit idling_on();
        return (sent_count < total_items - CALM_TAIL) && ((sent_count / 64) % 3 != 2);
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_item(logic kind, logic [15:0] x, logic [15:0] y, logic [7:0] idx);
        path_item_t it;
        it.kind  = kind;
        it.x     = x;
        it.y     = y;
        it.idx   = idx;
        it.drain = 1'b0;
        pending_q.insert(pending_q.size(), it);
    endtask

    // Sender: predict on each transfer, then offer the next pending item or idle.
    always @(posedge aclk) begin : driver
        path_item_t   nxt;
        path_result_t due;
        logic         offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                due = advance_polyline(on_bus);
                result_due_q.insert(result_due_q.size(), due);
                sent_count++;
            end
            if (!s_tvalid || s_tready) begin
                offer = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_q.size() != 0) begin
                    if (pending_q[0].drain && result_due_q.size() != 0) begin
                        // hold until every outstanding result is back
                    end else if (idling_on() && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(0, 9);
                    end else begin
                        offer = 1'b1;
                        nxt   = pending_q.pop_front();
                    end
                end
                s_tvalid <= offer;
                if (offer) begin
                    s_tdata <= {nxt.idx, nxt.y, nxt.x};
                    s_tuser <= nxt.kind;
                    on_bus  = nxt;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up.
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done  = 1'b1;
                recv_stall = HOLD_CYCLES;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if (idling_on() && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        path_result_t want;
        path_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[73:0];
            if (result_due_q.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = result_due_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected x=%h y=%h count=%0d length=%h err=%b",
                             $time, want.x, want.y, want.count, want.length, want.err);
                    $display("%0t:            actual x=%h y=%h count=%0d length=%h err=%b",
                             $time, got.x, got.y, got.count, got.length, got.err);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("polyline_length_accumulator regression: fail");
        $finish;
    end

    initial begin : sequencer
        path_item_t it;
        int         planned;
        int         n;

        // empty store, extremes of the coordinates, boundary reads
        queue_item(polylen_pkg::KIND_READ,   16'h0000, 16'h0000, 8'd0);
        queue_item(polylen_pkg::KIND_READ,   16'hFFFF, 16'hFFFF, 8'd255);
        queue_item(polylen_pkg::KIND_APPEND, 16'h8000, 16'h8000, 8'hFF);
        queue_item(polylen_pkg::KIND_READ,   16'h0000, 16'h0000, 8'd0);
        queue_item(polylen_pkg::KIND_READ,   16'h0000, 16'h0000, 8'd1);
        queue_item(polylen_pkg::KIND_APPEND, 16'h7FFF, 16'h7FFF, 8'h00);
        queue_item(polylen_pkg::KIND_APPEND, 16'h7FFF, 16'h8000, 8'h00);
        queue_item(polylen_pkg::KIND_APPEND, 16'h8000, 16'h7FFF, 8'h00);
        queue_item(polylen_pkg::KIND_APPEND, 16'h0000, 16'h0000, 8'h00);
        queue_item(polylen_pkg::KIND_APPEND, 16'h0000, 16'h0000, 8'h00);
        queue_item(polylen_pkg::KIND_APPEND, 16'h0001, 16'h0000, 8'h00);
        queue_item(polylen_pkg::KIND_APPEND, 16'h0100, 16'h0100, 8'h00);
        queue_item(polylen_pkg::KIND_APPEND, 16'hFFFF, 16'hFF00, 8'h00);
        queue_item(polylen_pkg::KIND_READ,   16'h0000, 16'h0000, 8'd1);
        queue_item(polylen_pkg::KIND_READ,   16'h0000, 16'h0000, 8'd8);
        queue_item(polylen_pkg::KIND_READ,   16'hFFFF, 16'hFFFF, 8'd9);
        queue_item(polylen_pkg::KIND_READ,   16'h0000, 16'h0000, 8'd255);
        queue_item(polylen_pkg::KIND_READ,   16'h0000, 16'h0000, 8'd128);
        planned = 9;

        // random phase: grow to a full store, then mostly reads and dropped appends
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            it.x     = pick_coord();
            it.y     = pick_coord();
            it.idx   = 8'($urandom);
            it.drain = (n == 400 || n == 800);
            if ((planned < polylen_pkg::MAX_POINTS) ? ($urandom_range(0, 1) == 0)
                                                    : ($urandom_range(0, 3) == 0)) begin
                it.kind = polylen_pkg::KIND_APPEND;
                if (planned < polylen_pkg::MAX_POINTS)
                    planned++;
            end else begin
                it.kind = polylen_pkg::KIND_READ;
                case ($urandom_range(0, 5))
                    0: ;
                    1: if (planned < polylen_pkg::MAX_POINTS) it.idx = 8'(planned);
                    default: if (planned > 0) it.idx = 8'($urandom_range(0, planned - 1));
                endcase
            end
            pending_q.insert(pending_q.size(), it);
        end
        total_items = pending_q.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (result_due_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (fail_count == 0 && result_due_q.size() == 0) begin
            $display("polyline_length_accumulator regression: pass");
        end else begin
            $display("polyline_length_accumulator regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/polylen_pkg.sv
sv/polyline_length_accumulator.sv
dv/polyline_length_accumulator_tb.sv
